// ===== hdl/wfc_pkg.sv =====
// Shared constants and types of the word frequency counter.
package wfc_pkg;

  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 4;
  localparam int TEXT_W  = 64;
  localparam int COUNT_W = 12;

  localparam logic [CHAR_W-1:0]  SPACE_CODE = 8'd32;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  localparam int DEF_TABLE_ENTRIES = 8;
  localparam int DEF_WORD_CHARS    = 8;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One closed word handed from the front to the back.
  typedef struct packed {
    logic [TEXT_W-1:0] word;
    logic [LEN_W-1:0]  length;
    logic              overlong;
    logic              emit;
  } cmd_t;

endpackage

// ===== hdl/wfc_if.sv =====
// Stream interfaces for characters in and table entries out.
interface wfc_char_if;
  logic                        valid;
  logic                        ready;
  logic [wfc_pkg::CHAR_W-1:0]  character;
  logic                        end_of_line;

  modport source (output valid, output character, output end_of_line, input ready);
  modport sink   (input valid, input character, input end_of_line, output ready);
endinterface

interface wfc_count_if;
  logic                         valid;
  logic                         ready;
  logic [wfc_pkg::TEXT_W-1:0]   word_text;
  logic [wfc_pkg::LEN_W-1:0]    word_length;
  logic [wfc_pkg::COUNT_W-1:0]  occurrences;
  logic                         was_truncated;
  logic                         words_dropped;
  logic                         last_entry;

  modport source (output valid, output word_text, output word_length, output occurrences,
                  output was_truncated, output words_dropped, output last_entry,
                  input ready);
  modport sink   (input valid, input word_text, input word_length, input occurrences,
                  input was_truncated, input words_dropped, input last_entry,
                  output ready);
endinterface

// ===== hdl/wfc_queue.sv =====
// Small command queue between the word builder and the table engine.
module wfc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wfc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output wfc_pkg::cmd_t head,
  output logic          empty
);
  import wfc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/wfc_front.sv =====
// Front end: takes characters, builds the current word and queues closed words.
module wfc_front #(
  parameter int WORD_CHARS = wfc_pkg::DEF_WORD_CHARS
) (
  input  logic          clk,
  input  logic          rst,
  wfc_char_if.sink      chars,
  output logic          push,
  output wfc_pkg::cmd_t push_cmd,
  input  logic          full
);
  import wfc_pkg::*;

  localparam int WORD_W = CHAR_W * WORD_CHARS;

  logic [WORD_W-1:0] cur_word;
  logic [LEN_W-1:0]  cur_len;
  logic              cur_overlong;
  logic              pending;

  logic              accept;
  logic              is_space;
  logic [WORD_W-1:0] app_word;
  logic [LEN_W-1:0]  app_len;
  logic              app_overlong;

  assign chars.ready = !pending && !full;
  assign accept      = chars.valid && chars.ready;
  assign is_space    = (chars.character == SPACE_CODE);

  always_comb begin
    app_word     = cur_word;
    app_len      = cur_len;
    app_overlong = cur_overlong;
    if (cur_len < LEN_W'(WORD_CHARS)) begin
      app_word = cur_word | (WORD_W'(chars.character) << {cur_len, 3'b000});
      app_len  = cur_len + 1'b1;
    end else begin
      app_overlong = 1'b1;
    end
  end

  // A space with end of line closes the word now and then pushes an empty word with emit once the queue has room.
  always_comb begin
    push     = 1'b0;
    push_cmd = '0;
    if (pending) begin
      push          = !full;
      push_cmd.emit = 1'b1;
    end else if (accept) begin
      if (is_space) begin
        push              = 1'b1;
        push_cmd.word     = TEXT_W'(cur_word);
        push_cmd.length   = cur_len;
        push_cmd.overlong = cur_overlong;
      end else if (chars.end_of_line) begin
        push              = 1'b1;
        push_cmd.word     = TEXT_W'(app_word);
        push_cmd.length   = app_len;
        push_cmd.overlong = app_overlong;
        push_cmd.emit     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_word     <= '0;
      cur_len      <= '0;
      cur_overlong <= 1'b0;
      pending      <= 1'b0;
    end else begin
      if (pending && !full) begin
        pending <= 1'b0;
      end
      if (accept) begin
        if (is_space || chars.end_of_line) begin
          cur_word     <= '0;
          cur_len      <= '0;
          cur_overlong <= 1'b0;
          pending      <= is_space && chars.end_of_line;
        end else begin
          cur_word     <= app_word;
          cur_len      <= app_len;
          cur_overlong <= app_overlong;
        end
      end
    end
  end

endmodule

// ===== hdl/wfc_back.sv =====
// Back end: looks words up in the table, counts them and emits the table at end of line.
module wfc_back #(
  parameter int TABLE_ENTRIES = wfc_pkg::DEF_TABLE_ENTRIES,
  parameter int WORD_CHARS    = wfc_pkg::DEF_WORD_CHARS
) (
  input  logic          clk,
  input  logic          rst,
  input  wfc_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  wfc_count_if.source   counts
);
  import wfc_pkg::*;

  localparam int WORD_W = CHAR_W * WORD_CHARS;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_CMP       = 3'd2;
  localparam logic [2:0] S_EMIT_WAIT = 3'd3;
  localparam logic [2:0] S_EMIT      = 3'd4;

  // Table memory, one registered read port at idx and one write port.
  logic [WORD_W-1:0]  mem_word  [TABLE_ENTRIES];
  logic [LEN_W-1:0]   mem_len   [TABLE_ENTRIES];
  logic [COUNT_W-1:0] mem_cnt   [TABLE_ENTRIES];
  logic               mem_trunc [TABLE_ENTRIES];

  logic [WORD_W-1:0]  rd_word;
  logic [LEN_W-1:0]   rd_len;
  logic [COUNT_W-1:0] rd_cnt;
  logic               rd_trunc;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_word;
  logic [LEN_W-1:0]   wr_len;
  logic [COUNT_W-1:0] wr_cnt;
  logic               wr_trunc;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_next;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   used_next;
  logic               drop;
  logic               drop_next;
  cmd_t               cmd;

  logic               out_valid;
  logic [TEXT_W-1:0]  out_word;
  logic [LEN_W-1:0]   out_len;
  logic [COUNT_W-1:0] out_cnt;
  logic               out_trunc;
  logic               out_drop;
  logic               out_last;
  logic               out_load;

  logic               match;
  logic               idx_last;
  logic               room;
  logic               out_free;

  assign match    = (rd_word == cmd.word[WORD_W-1:0]) && (rd_len == cmd.length);
  assign idx_last = (CNT_W'(idx) + 1'b1 == used);
  assign room     = (used < CNT_W'(TABLE_ENTRIES));
  assign out_free = !out_valid || counts.ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_word[wr_addr]  <= wr_word;
      mem_len[wr_addr]   <= wr_len;
      mem_cnt[wr_addr]   <= wr_cnt;
      mem_trunc[wr_addr] <= wr_trunc;
    end
    rd_word  <= mem_word[idx];
    rd_len   <= mem_len[idx];
    rd_cnt   <= mem_cnt[idx];
    rd_trunc <= mem_trunc[idx];
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    used_next  = used;
    drop_next  = drop;
    pop        = 1'b0;
    out_load   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_word    = cmd.word[WORD_W-1:0];
    wr_len     = cmd.length;
    wr_cnt     = COUNT_W'(1);
    wr_trunc   = cmd.overlong;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          pop      = 1'b1;
          idx_next = '0;
          if (used == '0) begin
            // Empty table: the word goes straight into the first entry.
            wr_en      = 1'b1;
            wr_addr    = '0;
            wr_word    = head.word[WORD_W-1:0];
            wr_len     = head.length;
            wr_trunc   = head.overlong;
            used_next  = CNT_W'(1);
            state_next = head.emit ? S_EMIT_WAIT : S_IDLE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (match || idx_last) begin
          if (match) begin
            wr_en    = 1'b1;
            wr_cnt   = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
            wr_trunc = rd_trunc | cmd.overlong;
          end else if (room) begin
            wr_en     = 1'b1;
            wr_addr   = IDX_W'(used);
            used_next = used + 1'b1;
          end else begin
            drop_next = 1'b1;
          end
          idx_next   = '0;
          state_next = cmd.emit ? S_EMIT_WAIT : S_IDLE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SCAN;
        end
      end
      S_EMIT_WAIT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (idx_last) begin
            used_next  = '0;
            drop_next  = 1'b0;
            idx_next   = '0;
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_EMIT_WAIT;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    if (out_load) begin
      out_word  <= TEXT_W'(rd_word);
      out_len   <= rd_len;
      out_cnt   <= rd_cnt;
      out_trunc <= rd_trunc;
      out_drop  <= drop;
      out_last  <= idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      used      <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      used  <= used_next;
      drop  <= drop_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (counts.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign counts.valid         = out_valid;
  assign counts.word_text     = out_word;
  assign counts.word_length   = out_len;
  assign counts.occurrences   = out_cnt;
  assign counts.was_truncated = out_trunc;
  assign counts.words_dropped = out_drop;
  assign counts.last_entry    = out_last;

endmodule

// ===== hdl/word_frequency_counter.sv =====
// Word frequency counter: counts the distinct words of a text line and emits the table.
// Characters enter the word builder one per cycle while the queue has room and no empty
// word is pending; each closed word goes to a two-deep queue, and a space with end of
// line also queues an empty word. The table engine holds the words in a memory with one
// registered read port and compares stored entries one at a time, through a scan and a
// compare state; the queue lets characters keep arriving meanwhile. At end of line the
// engine emits every entry in insertion order through a read-wait and an emit state,
// holding while the consumer stalls, and then starts the next line with an empty table.
// Words longer than WORD_CHARS are cut and marked, and a new word that finds all
// TABLE_ENTRIES entries in use is dropped and flagged on every entry of the line.
module word_frequency_counter #(
  parameter int TABLE_ENTRIES = wfc_pkg::DEF_TABLE_ENTRIES,
  parameter int WORD_CHARS    = wfc_pkg::DEF_WORD_CHARS
) (
  input  logic        clk,
  input  logic        rst,
  wfc_char_if.sink    chars,
  wfc_count_if.source counts
);
  import wfc_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  cmd_t head;
  logic empty;

  wfc_front #(
    .WORD_CHARS (WORD_CHARS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  wfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  wfc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .WORD_CHARS    (WORD_CHARS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .counts (counts)
  );

endmodule
